>>> sv/pss_pkg.sv
// Package for the plucked string voice: item, result, register and
// controller/datapath command types, plus fixed widths and codes.
// No dependencies.
`default_nettype none
package pss_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_FRAC = 16;
  localparam int MAX_DELAY = 2048;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int COEF_W    = COEF_FRAC + 1;
  localparam int MUL_W     = COEF_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PADDR_W   = 5;

  localparam logic [COEF_W-1:0] ONE_COEF = COEF_W'(1) << COEF_FRAC;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] REG_DELAY_LENGTH  = 3'd0;
  localparam logic [2:0] REG_LOWPASS_ALPHA = 3'd1;
  localparam logic [2:0] REG_DRY_MIX       = 3'd2;
  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd3;
  localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd4;
  localparam logic [2:0] REG_ACT_THRESHOLD = 3'd5;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [ADDR_W-1:0]          load_addr;
    logic                       last_of_buffer;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       active;
  } out_t;

  typedef struct packed {
    logic [11:0] delay_length;
    logic [16:0] lowpass_alpha;
    logic [16:0] dry_mix;
    logic [15:0] feedback_gain;
    logic [15:0] output_gain;
    logic [19:0] activity_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FD,
    MUL_FL,
    MUL_AW,
    MUL_AV,
    MUL_FDW,
    MUL_FLL,
    MUL_GN
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_RDW,
    S_RDV,
    S_MFD,
    S_MFL,
    S_MAW,
    S_MAV,
    S_LP,
    S_MFDW,
    S_MFLL,
    S_NEW,
    S_MG,
    S_Y,
    S_SUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     take;
    logic     clr_step;
    logic     write_item;
    logic     mod_start;
    logic     mod_step;
    logic     rd_new;
    logic     pos_update;
    logic     lat_w;
    logic     lat_v;
    mul_sel_t mul_sel;
    logic     lat_fd;
    logic     lat_fl;
    logic     acc_load;
    logic     lat_lp;
    logic     lat_n;
    logic     lat_y;
    logic     sum_update;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       pos_lt_len;
    logic       clr_last;
  } status_t;

endpackage
`default_nettype wire

>>> sv/pss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/pss_regs.sv
// Configuration register file behind the APB-style port.
// Depends on pss_pkg.
`default_nettype none
module pss_regs
  import pss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_length       <= 12'd100;
      cfg.lowpass_alpha      <= 17'd32768;
      cfg.dry_mix            <= 17'd0;
      cfg.feedback_gain      <= 16'd64880;
      cfg.output_gain        <= 16'd32768;
      cfg.activity_threshold <= 20'd33;
    end else if (wr) begin
      case (idx)
        REG_DELAY_LENGTH:  cfg.delay_length       <= pwdata[11:0];
        REG_LOWPASS_ALPHA: cfg.lowpass_alpha      <= pwdata[16:0];
        REG_DRY_MIX:       cfg.dry_mix            <= pwdata[16:0];
        REG_FEEDBACK_GAIN: cfg.feedback_gain      <= pwdata[15:0];
        REG_OUTPUT_GAIN:   cfg.output_gain        <= pwdata[15:0];
        REG_ACT_THRESHOLD: cfg.activity_threshold <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY_LENGTH:  prdata = {20'd0, cfg.delay_length};
      REG_LOWPASS_ALPHA: prdata = {15'd0, cfg.lowpass_alpha};
      REG_DRY_MIX:       prdata = {15'd0, cfg.dry_mix};
      REG_FEEDBACK_GAIN: prdata = {16'd0, cfg.feedback_gain};
      REG_OUTPUT_GAIN:   prdata = {16'd0, cfg.output_gain};
      REG_ACT_THRESHOLD: prdata = {12'd0, cfg.activity_threshold};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/pss_ctrl.sv
// Controller: sequences the clearing pass, the delay-line reads, the shared
// multiplier steps and the result hand-off. Depends on pss_pkg.
`default_nettype none
module pss_ctrl
  import pss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  output logic         result_valid,
  input  wire logic    result_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t      state, state_next;
  logic [3:0]  mod_cnt;
  logic        slot_free;
  logic        take;

  assign item_ready = (state == S_IDLE);
  assign take       = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      mod_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECODE) begin
        mod_cnt <= '0;
      end else if (state == S_MOD) begin
        mod_cnt <= mod_cnt + 4'd1;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (status.clr_last) state_next = S_IDLE;
      S_IDLE:   if (take) state_next = S_DECODE;
      S_DECODE: begin
        if (status.action != ACT_TICK) begin
          state_next = S_DONE;
        end else if (status.pos_lt_len) begin
          state_next = S_RDW;
        end else begin
          state_next = S_MOD;
        end
      end
      S_MOD:    if (mod_cnt == 4'(ADDR_W - 1)) state_next = S_RDW;
      S_RDW:    state_next = S_RDV;
      S_RDV:    state_next = S_MFD;
      S_MFD:    state_next = S_MFL;
      S_MFL:    state_next = S_MAW;
      S_MAW:    state_next = S_MAV;
      S_MAV:    state_next = S_LP;
      S_LP:     state_next = S_MFDW;
      S_MFDW:   state_next = S_MFLL;
      S_MFLL:   state_next = S_NEW;
      S_NEW:    state_next = S_MG;
      S_MG:     state_next = S_Y;
      S_Y:      state_next = S_SUM;
      S_SUM:    state_next = S_DONE;
      S_DONE:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    case (state)
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_IDLE:   cmd.take = take;
      S_DECODE: begin
        cmd.mod_start  = 1'b1;
        cmd.write_item = (status.action == ACT_LOAD) || (status.action == ACT_CLEAR);
      end
      S_MOD:    cmd.mod_step = 1'b1;
      S_RDW: begin
        cmd.rd_new     = 1'b1;
        cmd.pos_update = 1'b1;
      end
      S_RDV:    cmd.lat_w = 1'b1;
      S_MFD: begin
        cmd.lat_v   = 1'b1;
        cmd.mul_sel = MUL_FD;
      end
      S_MFL: begin
        cmd.lat_fd  = 1'b1;
        cmd.mul_sel = MUL_FL;
      end
      S_MAW: begin
        cmd.lat_fl  = 1'b1;
        cmd.mul_sel = MUL_AW;
      end
      S_MAV: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_AV;
      end
      S_LP:     cmd.lat_lp = 1'b1;
      S_MFDW:   cmd.mul_sel = MUL_FDW;
      S_MFLL: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_FLL;
      end
      S_NEW:    cmd.lat_n = 1'b1;
      S_MG:     cmd.mul_sel = MUL_GN;
      S_Y:      cmd.lat_y = 1'b1;
      S_SUM:    cmd.sum_update = 1'b1;
      S_DONE:   cmd.out_load = slot_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/pss_datapath.sv
// Datapath: delay-line memory, position reduction, shared 18x18 multiplier
// with accumulator, saturation, level sum and result register.
// Depends on pss_pkg and pss_ram.
`default_nettype none
module pss_datapath
  import pss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  input  wire cmd_t cmd,
  output status_t   status,
  output out_t      result
);

  localparam int SUM_W = PROD_W + 1;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] smax;
    logic signed [SUM_W-1:0] smin;
    smax = SUM_W'((SUM_W'(1) << (SAMPLE_W - 1)) - SUM_W'(1));
    smin = -(SUM_W'(1) << (SAMPLE_W - 1));
    if (x > smax) begin
      return smax[SAMPLE_W-1:0];
    end else if (x < smin) begin
      return smin[SAMPLE_W-1:0];
    end
    return x[SAMPLE_W-1:0];
  endfunction

  in_t                        cur;
  logic [ADDR_W-1:0]          position;
  logic [ADDR_W-1:0]          wpos;
  logic [ADDR_W-1:0]          rem;
  logic [ADDR_W-1:0]          dvd;
  logic [ADDR_W-1:0]          clr_cnt;
  logic signed [SAMPLE_W-1:0] w, v, lp, n, y;
  logic [15:0]                fd, fl;
  logic signed [PROD_W-1:0]   prod, acc;
  logic [31:0]                level_sum;
  logic                       flag;

  logic [LEN_W-1:0]           len_eff;
  logic [COEF_W-1:0]          a_eff, d_eff, one_m_a, one_m_d;
  logic [LEN_W-1:0]           rem_sh, rem_sub, p_inc;
  logic [ADDR_W-1:0]          pos_new;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [SUM_W-1:0]    sum_all, sum_sh, g_sh, y_pre;
  logic [SAMPLE_W:0]          mag;
  logic [32:0]                lsum;
  logic [31:0]                lsum_sat;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0]        mem_wdata, mem_rdata;

  always_comb begin
    if (cfg.delay_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.delay_length > LEN_W'(MAX_DELAY)) begin
      len_eff = LEN_W'(MAX_DELAY);
    end else begin
      len_eff = cfg.delay_length;
    end
  end

  assign a_eff   = (cfg.lowpass_alpha > ONE_COEF) ? ONE_COEF : cfg.lowpass_alpha;
  assign d_eff   = (cfg.dry_mix > ONE_COEF) ? ONE_COEF : cfg.dry_mix;
  assign one_m_a = ONE_COEF - a_eff;
  assign one_m_d = ONE_COEF - d_eff;

  assign rem_sh  = {rem, dvd[ADDR_W-1]};
  assign rem_sub = rem_sh - len_eff;
  assign p_inc   = {1'b0, rem} + LEN_W'(1);
  assign pos_new = (p_inc == len_eff) ? '0 : p_inc[ADDR_W-1:0];

  assign status.action     = cur.action;
  assign status.pos_lt_len = ({1'b0, position} < len_eff);
  assign status.clr_last   = (clr_cnt == ADDR_W'(MAX_DELAY - 1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_FD: begin
        mul_a = {2'b00, cfg.feedback_gain};
        mul_b = {1'b0, d_eff};
      end
      MUL_FL: begin
        mul_a = {2'b00, cfg.feedback_gain};
        mul_b = {1'b0, one_m_d};
      end
      MUL_AW: begin
        mul_a = {1'b0, a_eff};
        mul_b = {{2{w[SAMPLE_W-1]}}, w};
      end
      MUL_AV: begin
        mul_a = {1'b0, one_m_a};
        mul_b = {{2{v[SAMPLE_W-1]}}, v};
      end
      MUL_FDW: begin
        mul_a = {2'b00, fd};
        mul_b = {{2{w[SAMPLE_W-1]}}, w};
      end
      MUL_FLL: begin
        mul_a = {2'b00, fl};
        mul_b = {{2{lp[SAMPLE_W-1]}}, lp};
      end
      MUL_GN: begin
        mul_a = {2'b00, cfg.output_gain};
        mul_b = {{2{n[SAMPLE_W-1]}}, n};
      end
      default: ;
    endcase
  end

  assign sum_all = {acc[PROD_W-1], acc} + {prod[PROD_W-1], prod};
  assign sum_sh  = sum_all >>> COEF_FRAC;
  assign g_sh    = $signed({prod[PROD_W-1], prod}) >>> (SAMPLE_W - 1);
  assign y_pre   = g_sh + {{(SUM_W-SAMPLE_W){cur.sample_in[SAMPLE_W-1]}}, cur.sample_in};

  assign mag      = y[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {y[SAMPLE_W-1], y}) : {1'b0, y};
  assign lsum     = {1'b0, level_sum} + {{(32-SAMPLE_W){1'b0}}, mag};
  assign lsum_sat = lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wpos;
    mem_wdata = n;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (cmd.write_item) begin
      mem_we    = 1'b1;
      mem_waddr = cur.load_addr;
      mem_wdata = (cur.action == ACT_LOAD) ? cur.sample_in : '0;
    end else if (cmd.lat_n) begin
      mem_we    = 1'b1;
      mem_waddr = wpos;
      mem_wdata = sat_sample(sum_sh);
    end
  end

  assign mem_raddr = cmd.rd_new ? pos_new : rem;

  pss_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      level_sum <= '0;
      flag      <= 1'b0;
      clr_cnt   <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.pos_update) begin
        position <= pos_new;
      end
      if (cmd.write_item) begin
        flag <= (cur.action == ACT_LOAD);
      end
      if (cmd.sum_update) begin
        if (cur.last_of_buffer) begin
          flag      <= (lsum_sat > {12'd0, cfg.activity_threshold});
          level_sum <= '0;
        end else begin
          level_sum <= lsum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur <= item;
      y   <= '0;
    end
    if (cmd.mod_start) begin
      rem <= status.pos_lt_len ? position : '0;
      dvd <= position;
    end
    if (cmd.mod_step) begin
      rem <= (rem_sh >= len_eff) ? rem_sub[ADDR_W-1:0] : rem_sh[ADDR_W-1:0];
      dvd <= {dvd[ADDR_W-2:0], 1'b0};
    end
    if (cmd.pos_update) begin
      wpos <= pos_new;
    end
    if (cmd.lat_w) begin
      w <= mem_rdata;
    end
    if (cmd.lat_v) begin
      v <= mem_rdata;
    end
    prod <= mul_a * mul_b;
    if (cmd.lat_fd) begin
      fd <= prod[COEF_FRAC+15:COEF_FRAC];
    end
    if (cmd.lat_fl) begin
      fl <= prod[COEF_FRAC+15:COEF_FRAC];
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end
    if (cmd.lat_lp) begin
      lp <= sum_sh[SAMPLE_W-1:0];
    end
    if (cmd.lat_n) begin
      n <= sat_sample(sum_sh);
    end
    if (cmd.lat_y) begin
      y <= sat_sample(y_pre);
    end
    if (cmd.out_load) begin
      result.sample_out <= y;
      result.active     <= flag;
    end
  end

endmodule
`default_nettype wire

>>> sv/plucked_string_synth_voice.sv
// Plucked string voice top level. A tick first reduces the position modulo a shortened
// delay_length (11-step remainder loop) when the position is not below it; load, clear
// and unused items skip the multiplier steps. One item is in work at a time: a new item
// is taken only after the last result is loaded, and ticks are paced by the shared 18x18
// multiplier (seven products); a stalled result holds the block. After reset a clearing
// pass zeroes all 2048 delay memory entries before any item is taken.
`default_nettype none
module plucked_string_synth_voice
  import pss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire in_t                item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output out_t                    result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  pss_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
`default_nettype wire
